// ----- sv/plist_pkg.sv -----
`timescale 1ns / 1ps

package plist_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_SEARCH = 3'd2,
		CMD_UPDATE = 3'd3,
		CMD_GET    = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_e;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_REM,
		OP_UPD
	} cell_op_e;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] read_value;
		logic [6:0]         found_position;
		logic [6:0]         count;
		logic               is_full;
		logic               is_empty;
	} rsp_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_e op;
		logic     scan_search;
		logic     scan_at_pos;
	} cell_ctl_t;

	// Word handed from cell to cell while a scan walks the chain.
	typedef struct packed {
		logic        tok;
		logic        hit;
		logic [6:0]  pos;
		logic [31:0] data;
	} scan_t;

endpackage

// ----- sv/positional_list_engine_top.sv -----
`timescale 1ns / 1ps

// Channel | Handshake            | Word
// --------+----------------------+----------------------------------------
// req     | req_valid, req_stall | cmd, position, value
// rsp     | rsp_valid, rsp_stall | ok, read_value, found_position, count,
//         |                      | is_full, is_empty
//
// One command is in flight at a time. A scan token walks the chain of cells
// one cell per cycle; the response word is loaded once the token has left the
// last cell, and the next command can be accepted after that load.
// Reset clears the count and the control state but not the stored entries.
// A finished response waits in an output register while rsp_stall holds it;
// the next command is accepted meanwhile, and the list changes on its load.

module positional_list_engine_top import plist_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 7) ? CW : 7) + 1;

	state_e        state_q;
	state_e        state_d;
	logic          start_q;
	logic          start_d;
	logic          load;
	req_t          item_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic          rsp_valid_q;
	cell_ctl_t     ctl;
	cell_op_e      op_ok;

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] cnt_new_x;
	logic          pos_nz;
	logic          in_list;
	logic          ins_ok;

	logic          res_hit_q;
	logic [6:0]    res_pos_q;
	logic [31:0]   res_data_q;

	logic [31:0]   ent_pad [CAPACITY+2];
	scan_t         scan_w  [CAPACITY+1];
	logic [CAPACITY:0] tok_vec;

	// Cell chain.
	assign ent_pad[0]          = '0;
	assign ent_pad[CAPACITY+1] = '0;
	assign scan_w[0]           = '{tok: start_q, hit: 1'b0, pos: 7'd0, data: 32'd0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plist_cell #(
			.CAPACITY(CAPACITY),
			.INDEX   (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.position(item_q.position),
			.count   (count_q),
			.value   (item_q.value),
			.left    (ent_pad[i]),
			.right   (ent_pad[i+2]),
			.entry   (ent_pad[i+1]),
			.scan_in (scan_w[i]),
			.scan_out(scan_w[i+1])
		);
		assign tok_vec[i] = scan_w[i+1].tok;
	end
	assign tok_vec[CAPACITY] = start_q;

	// Command checks against the current count.
	assign pos_x   = XW'(item_q.position);
	assign cnt_x   = XW'(count_q);
	assign pos_nz  = pos_x != '0;
	assign in_list = pos_nz && pos_x <= cnt_x;
	assign ins_ok  = cnt_x < XW'(CAPACITY) && pos_nz && pos_x <= cnt_x + XW'(1);

	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		op_ok   = OP_HOLD;
		unique case (item_q.cmd)
			CMD_INSERT: begin
				if (ins_ok) begin
					rsp_d.ok = 1'b1;
					op_ok    = OP_INS;
					count_d  = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (in_list) begin
					rsp_d.ok         = 1'b1;
					rsp_d.read_value = res_data_q;
					op_ok            = OP_REM;
					count_d          = count_q - CW'(1);
				end
			end
			CMD_SEARCH: begin
				rsp_d.ok = 1'b1;
				if (res_hit_q) begin
					rsp_d.found_position = res_pos_q;
				end
			end
			CMD_UPDATE: begin
				if (in_list) begin
					rsp_d.ok = 1'b1;
					op_ok    = OP_UPD;
				end
			end
			CMD_GET: begin
				if (in_list) begin
					rsp_d.ok         = 1'b1;
					rsp_d.read_value = res_data_q;
				end
			end
			default: begin
				rsp_d.ok = 1'b0;
			end
		endcase
		cnt_new_x      = XW'(count_d);
		rsp_d.count    = cnt_new_x[6:0];
		rsp_d.is_full  = cnt_new_x == XW'(CAPACITY);
		rsp_d.is_empty = count_d == '0;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		start_d         = 1'b0;
		load            = 1'b0;
		req_stall       = 1'b1;
		ctl.op          = OP_HOLD;
		ctl.scan_search = item_q.cmd == CMD_SEARCH;
		ctl.scan_at_pos = item_q.cmd == CMD_REMOVE || item_q.cmd == CMD_GET;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					start_d = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_w[CAPACITY].tok) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load    = 1'b1;
					ctl.op  = op_ok;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The token does not stay at the end of the chain, so its result is kept here.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_q <= req;
		end
		if (state_q == S_SCAN && scan_w[CAPACITY].tok) begin
			res_hit_q  <= scan_w[CAPACITY].hit;
			res_pos_q  <= scan_w[CAPACITY].pos;
			res_data_q <= scan_w[CAPACITY].data;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(CAPACITY))
		else $error("entry count above capacity");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one scan token in the chain");

	a_rsp_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response loaded outside the final cycle");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !rsp_d.ok) |=> $stable(count_q))
		else $error("rejected command changed the count");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.is_full && rsp_q.is_empty))
		else $error("list reported full and empty at once");

endmodule

// ----- sv/plist_cell.sv -----
`timescale 1ns / 1ps

module plist_cell import plist_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int INDEX    = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cell_ctl_t                        ctl,
	input  logic [6:0]                       position,
	input  logic [$clog2(CAPACITY+1)-1:0]    count,
	input  logic [31:0]                      value,
	input  logic [31:0]                      left,
	input  logic [31:0]                      right,
	output logic [31:0]                      entry,
	input  scan_t                            scan_in,
	output scan_t                            scan_out
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 7) ? CW : 7) + 1;

	logic [XW-1:0] p_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [31:0]   entry_q;
	logic [31:0]   entry_d;
	logic          match;
	scan_t         scan_q;
	scan_t         scan_d;

	assign p_x   = XW'(INDEX + 1);
	assign pos_x = XW'(position);
	assign cnt_x = XW'(count);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			OP_INS: begin
				if (p_x == pos_x) begin
					entry_d = value;
				end else if (p_x > pos_x && p_x <= cnt_x + XW'(1)) begin
					entry_d = left;
				end
			end
			OP_REM: begin
				if (p_x >= pos_x && p_x < cnt_x) begin
					entry_d = right;
				end
			end
			OP_UPD: begin
				if (p_x == pos_x) begin
					entry_d = value;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign match = (ctl.scan_search && p_x <= cnt_x && entry_q == value) ||
		(ctl.scan_at_pos && p_x == pos_x);

	// The first hit along the chain is kept; later cells pass it on untouched.
	always_comb begin
		scan_d = scan_in;
		if (scan_in.tok && !scan_in.hit && match) begin
			scan_d.hit  = 1'b1;
			scan_d.pos  = 7'(INDEX + 1);
			scan_d.data = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	assign scan_out = scan_q;

endmodule
